### hdl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Needs a clk and an active-high rst in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational check, masked during reset.
`define CHK_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication into the next cycle, masked during reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication into the next cycle, checked during reset too.
`define CHK_STEP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/wpsp_pkg.sv
// Shared widths, constants, types and helper functions of the projection block.
// No dependencies; used by every module of the block.
`default_nettype none

package wpsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int COEF_N    = 16;
  localparam int TAB_N     = 2 * COEF_N;
  localparam int IDX_W     = $clog2(TAB_N);
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W - FRAC_BITS + 2;

  localparam int PIN_SCALE = 100;
  localparam int PIN_W     = DATA_W + 7;
  localparam int NUM_W     = PIN_W + FRAC_BITS + 1;

  // ndc is clamped to +-2^NDC_LOG
  localparam int NDC_LOG   = 44;
  localparam int QBITS     = NDC_LOG + 1;
  localparam int NDC_W     = QBITS + 1;
  localparam int REM_W     = DATA_W - 1;

  // viewport scaling input clamp, large enough to saturate any result
  localparam int CL_LOG    = 34;
  localparam int CL_W      = CL_LOG + 2;
  localparam int VP_W      = 16;
  localparam int SCL_W     = CL_W + VP_W + 1;
  localparam int SUM_W     = SCL_W + 3;

  localparam int PIN_VP_W  = 800;
  localparam int PIN_VP_H  = 600;
  localparam logic signed [SUM_W-1:0] PIN_CX_Q = SUM_W'((PIN_VP_W / 2) * (2 ** FRAC_BITS));
  localparam logic signed [SUM_W-1:0] PIN_CY_Q = SUM_W'((PIN_VP_H / 2) * (2 ** FRAC_BITS));

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VP_LEFT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VP_TOP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VP_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VP_HEIGHT   = 3'd4;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t ONE_Q = word_t'(2 ** FRAC_BITS);

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QBITS-1:0] work;
  } lane_t;

  typedef struct packed {
    logic             vis;
    logic             cam;
    logic             neg_x;
    logic             neg_y;
    logic             ov_x;
    logic             ov_y;
    logic [REM_W-1:0] den;
    lane_t            lx;
    lane_t            ly;
  } div_t;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic lane_t div_bit(input lane_t l, input logic [REM_W-1:0] den);
    logic [REM_W:0] r2;
    logic           ge;
    lane_t          o;
    r2     = {l.rem, l.work[QBITS-1]};
    ge     = (r2 >= {1'b0, den});
    o.rem  = ge ? REM_W'(r2 - {1'b0, den}) : r2[REM_W-1:0];
    o.work = {l.work[QBITS-2:0], ge};
    return o;
  endfunction

  function automatic word_t sat32(input logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (v[SUM_W-1:DATA_W-1] == '0) || (v[SUM_W-1:DATA_W-1] == '1);
    if (fits) begin
      return v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

### hdl/wpsp_matvec.sv
// Two-stage 4x4 fixed-point matrix by vector product: products, then sums.
// Depends on wpsp_pkg.
`default_nettype none

module wpsp_matvec (
  input  logic           clk,
  input  logic           en,
  input  wpsp_pkg::word_t coef [wpsp_pkg::COEF_N],
  input  wpsp_pkg::word_t vin  [4],
  output wpsp_pkg::word_t vout [4]
);

  logic signed [wpsp_pkg::PROD_W-1:0] prod [wpsp_pkg::COEF_N];
  logic signed [wpsp_pkg::ACC_W-1:0]  acc  [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < wpsp_pkg::COEF_N; i++) begin
        prod[i] <= coef[i] * vin[i[1:0]];
      end
    end
  end

  // each term floors by the fraction shift before the row sum
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      acc[r] = '0;
      for (int c = 0; c < 4; c++) begin
        acc[r] = acc[r] + wpsp_pkg::ACC_W'(prod[r*4+c] >>> wpsp_pkg::FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        vout[r] <= wpsp_pkg::sat32(wpsp_pkg::SUM_W'(acc[r]));
      end
    end
  end

endmodule

`default_nettype wire

### hdl/wpsp_divider.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing
// one divisor. Depends on wpsp_pkg.
`default_nettype none

module wpsp_divider (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  wpsp_pkg::div_t  din,
  output logic            out_valid,
  output wpsp_pkg::div_t  dout
);

  logic [wpsp_pkg::QBITS-1:0]   vld;

  for (genvar i = 0; i < wpsp_pkg::QBITS; i++) begin : g_stage
    wpsp_pkg::div_t src;
    wpsp_pkg::div_t nxt;
    wpsp_pkg::div_t q;

    if (i == 0) begin : g_first
      assign src = din;
    end else begin : g_rest
      assign src = g_stage[i-1].q;
    end

    always_comb begin
      nxt    = src;
      nxt.lx = wpsp_pkg::div_bit(src.lx, src.den);
      nxt.ly = wpsp_pkg::div_bit(src.ly, src.den);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[wpsp_pkg::QBITS-2:0], in_valid};
    end
  end

  assign out_valid = vld[wpsp_pkg::QBITS-1];
  assign dout      = g_stage[wpsp_pkg::QBITS-1].q;

endmodule

`default_nettype wire

### hdl/world_point_screen_projection.sv
// World point to screen projection. Takes one item per cycle while item_stall
// is low. A project item passes through the two matrix products, the division
// setup, the pipelined divider (one quotient bit per stage) and the viewport
// scaling and saturation before its result appears. A load item writes the
// coefficient table at its transfer and gives no result; a load waits while
// an earlier project item has yet to read the projection matrix. The whole
// pipeline holds while a result is stalled.
// Depends on wpsp_pkg, wpsp_matvec and wpsp_divider.
`default_nettype none

module world_point_screen_projection (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              opcode,
  input  logic [wpsp_pkg::IDX_W-1:0]        coef_index,
  input  logic signed [wpsp_pkg::DATA_W-1:0] coef_value,
  input  logic signed [wpsp_pkg::DATA_W-1:0] world_x,
  input  logic signed [wpsp_pkg::DATA_W-1:0] world_y,
  input  logic signed [wpsp_pkg::DATA_W-1:0] world_z,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              visible,
  output logic signed [wpsp_pkg::DATA_W-1:0] screen_x,
  output logic signed [wpsp_pkg::DATA_W-1:0] screen_y,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wpsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wpsp_pkg::VP_W-1:0]         cfg_data
);

  typedef struct packed {
    logic signed [wpsp_pkg::PIN_W-1:0] px;
    logic signed [wpsp_pkg::PIN_W-1:0] py;
    wpsp_pkg::word_t                   z;
  } pin_t;

  typedef struct packed {
    logic                               vis;
    logic                               cam;
    logic signed [wpsp_pkg::NDC_W-1:0]  nx;
    logic signed [wpsp_pkg::NDC_W-1:0]  ny;
    logic signed [wpsp_pkg::SCL_W-1:0]  prodx;
    logic signed [wpsp_pkg::SCL_W-1:0]  prody;
  } scale_t;

  localparam logic signed [wpsp_pkg::PIN_W-1:0] PIN_K = wpsp_pkg::PIN_W'(wpsp_pkg::PIN_SCALE);
  localparam logic [wpsp_pkg::QBITS-1:0] NDC_LIMIT = wpsp_pkg::QBITS'(1) << wpsp_pkg::NDC_LOG;
  localparam logic signed [wpsp_pkg::NDC_W:0] ONE_N = (wpsp_pkg::NDC_W + 1)'(wpsp_pkg::ONE_Q);
  localparam logic signed [wpsp_pkg::CL_W-1:0] CL_MAX =
    wpsp_pkg::CL_W'(1) <<< wpsp_pkg::CL_LOG;

  wpsp_pkg::word_t coef_tab [wpsp_pkg::TAB_N];
  logic                       camera_mode;
  logic [wpsp_pkg::VP_W-1:0]  vp_left;
  logic [wpsp_pkg::VP_W-1:0]  vp_top;
  logic [wpsp_pkg::VP_W-1:0]  vp_width;
  logic [wpsp_pkg::VP_W-1:0]  vp_height;

  logic adv;
  logic accept;
  logic v1, v2, v3, v4, v5, vf1;

  wpsp_pkg::word_t coef_v [wpsp_pkg::COEF_N];
  wpsp_pkg::word_t coef_p [wpsp_pkg::COEF_N];
  wpsp_pkg::word_t pt     [4];
  wpsp_pkg::word_t eye    [4];
  wpsp_pkg::word_t clip   [4];

  pin_t pin_in, pin1, pin2, pin3, pin4;

  wpsp_pkg::div_t d5, d5_next, dq;
  logic           dv;
  scale_t         f1, f1_next;

  logic signed [wpsp_pkg::SUM_W-1:0] sum_x;
  logic signed [wpsp_pkg::SUM_W-1:0] sum_y;

  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv || (opcode == wpsp_pkg::OP_LOAD && (v1 || v2));
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_mode <= 1'b0;
      vp_left     <= '0;
      vp_top      <= '0;
      vp_width    <= wpsp_pkg::VP_W'(wpsp_pkg::PIN_VP_W);
      vp_height   <= wpsp_pkg::VP_W'(wpsp_pkg::PIN_VP_H);
    end else if (cfg_valid) begin
      case (cfg_index)
        wpsp_pkg::REG_CAMERA_MODE: camera_mode <= cfg_data[0];
        wpsp_pkg::REG_VP_LEFT:     vp_left     <= cfg_data;
        wpsp_pkg::REG_VP_TOP:      vp_top      <= cfg_data;
        wpsp_pkg::REG_VP_WIDTH:    vp_width    <= cfg_data;
        wpsp_pkg::REG_VP_HEIGHT:   vp_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wpsp_pkg::TAB_N; i++) begin
        coef_tab[i] <= '0;
      end
    end else if (accept && opcode == wpsp_pkg::OP_LOAD) begin
      coef_tab[coef_index] <= coef_value;
    end
  end

  always_comb begin
    for (int i = 0; i < wpsp_pkg::COEF_N; i++) begin
      coef_v[i] = coef_tab[i];
      coef_p[i] = coef_tab[wpsp_pkg::COEF_N + i];
    end
  end

  assign pt[0] = world_x;
  assign pt[1] = world_y;
  assign pt[2] = world_z;
  assign pt[3] = wpsp_pkg::ONE_Q;

  wpsp_matvec u_view (
    .clk  (clk),
    .en   (adv),
    .coef (coef_v),
    .vin  (pt),
    .vout (eye)
  );

  wpsp_matvec u_proj (
    .clk  (clk),
    .en   (adv),
    .coef (coef_p),
    .vin  (eye),
    .vout (clip)
  );

  // pinhole numerators ride alongside the matrix stages
  always_comb begin
    pin_in.px = wpsp_pkg::PIN_W'(world_x) * PIN_K;
    pin_in.py = wpsp_pkg::PIN_W'(world_y) * PIN_K;
    pin_in.z  = world_z;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pin1 <= pin_in;
      pin2 <= pin1;
      pin3 <= pin2;
      pin4 <= pin3;
    end
  end

  // division setup: magnitudes, divisor, overflow past the ndc clamp
  always_comb begin
    logic signed [wpsp_pkg::NUM_W-1:0] num_x;
    logic signed [wpsp_pkg::NUM_W-1:0] num_y;
    logic [wpsp_pkg::NUM_W-1:0]        mag_x;
    logic [wpsp_pkg::NUM_W-1:0]        mag_y;
    wpsp_pkg::word_t                   den_raw;
    if (camera_mode) begin
      num_x   = wpsp_pkg::NUM_W'(clip[0]) <<< wpsp_pkg::FRAC_BITS;
      num_y   = wpsp_pkg::NUM_W'(clip[1]) <<< wpsp_pkg::FRAC_BITS;
      den_raw = clip[3];
    end else begin
      num_x   = wpsp_pkg::NUM_W'(pin4.px) <<< wpsp_pkg::FRAC_BITS;
      num_y   = wpsp_pkg::NUM_W'(pin4.py) <<< wpsp_pkg::FRAC_BITS;
      den_raw = pin4.z;
    end
    mag_x         = num_x[wpsp_pkg::NUM_W-1] ? -num_x : num_x;
    mag_y         = num_y[wpsp_pkg::NUM_W-1] ? -num_y : num_y;
    d5_next.vis   = (den_raw > 0);
    d5_next.cam   = camera_mode;
    d5_next.neg_x = num_x[wpsp_pkg::NUM_W-1];
    d5_next.neg_y = num_y[wpsp_pkg::NUM_W-1];
    // a nonpositive divisor is replaced; that result is zeroed anyway
    d5_next.den   = d5_next.vis ? den_raw[wpsp_pkg::REM_W-1:0] : wpsp_pkg::REM_W'(1);
    d5_next.lx.rem  = wpsp_pkg::REM_W'(mag_x[wpsp_pkg::NUM_W-1:wpsp_pkg::QBITS]);
    d5_next.ly.rem  = wpsp_pkg::REM_W'(mag_y[wpsp_pkg::NUM_W-1:wpsp_pkg::QBITS]);
    d5_next.lx.work = mag_x[wpsp_pkg::QBITS-1:0];
    d5_next.ly.work = mag_y[wpsp_pkg::QBITS-1:0];
    d5_next.ov_x    = (d5_next.lx.rem >= d5_next.den);
    d5_next.ov_y    = (d5_next.ly.rem >= d5_next.den);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d5 <= d5_next;
    end
  end

  wpsp_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v5),
    .din       (d5),
    .out_valid (dv),
    .dout      (dq)
  );

  function automatic logic signed [wpsp_pkg::NDC_W-1:0] ndc_of(
    input logic [wpsp_pkg::QBITS-1:0] q, input logic ov, input logic neg);
    logic [wpsp_pkg::QBITS-1:0] qm;
    qm = (ov || q > NDC_LIMIT) ? NDC_LIMIT : q;
    return neg ? -wpsp_pkg::NDC_W'(qm) : wpsp_pkg::NDC_W'(qm);
  endfunction

  function automatic logic signed [wpsp_pkg::CL_W-1:0] clamp_cl(
    input logic signed [wpsp_pkg::NDC_W:0] v);
    if (v > (wpsp_pkg::NDC_W + 1)'(CL_MAX)) begin
      return CL_MAX;
    end else if (v < -(wpsp_pkg::NDC_W + 1)'(CL_MAX)) begin
      return -CL_MAX;
    end else begin
      return v[wpsp_pkg::CL_W-1:0];
    end
  endfunction

  always_comb begin
    logic signed [wpsp_pkg::NDC_W:0] ax;
    logic signed [wpsp_pkg::NDC_W:0] ay;
    f1_next.vis = dq.vis;
    f1_next.cam = dq.cam;
    f1_next.nx  = ndc_of(dq.lx.work, dq.ov_x, dq.neg_x);
    f1_next.ny  = ndc_of(dq.ly.work, dq.ov_y, dq.neg_y);
    ax = (wpsp_pkg::NDC_W + 1)'(f1_next.nx) + ONE_N;
    ay = ONE_N - (wpsp_pkg::NDC_W + 1)'(f1_next.ny);
    f1_next.prodx = wpsp_pkg::SCL_W'(clamp_cl(ax)) *
                    wpsp_pkg::SCL_W'($signed({1'b0, vp_width}));
    f1_next.prody = wpsp_pkg::SCL_W'(clamp_cl(ay)) *
                    wpsp_pkg::SCL_W'($signed({1'b0, vp_height}));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1 <= f1_next;
    end
  end

  always_comb begin
    if (f1.cam) begin
      sum_x = $signed(wpsp_pkg::SUM_W'({vp_left, {wpsp_pkg::FRAC_BITS{1'b0}}})) +
              wpsp_pkg::SUM_W'(f1.prodx >>> 1);
      sum_y = $signed(wpsp_pkg::SUM_W'({vp_top, {wpsp_pkg::FRAC_BITS{1'b0}}})) +
              wpsp_pkg::SUM_W'(f1.prody >>> 1);
    end else begin
      sum_x = wpsp_pkg::PIN_CX_Q + wpsp_pkg::SUM_W'(f1.nx);
      sum_y = wpsp_pkg::PIN_CY_Q - wpsp_pkg::SUM_W'(f1.ny);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      visible  <= f1.vis;
      screen_x <= f1.vis ? wpsp_pkg::sat32(sum_x) : '0;
      screen_y <= f1.vis ? wpsp_pkg::sat32(sum_y) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      vf1          <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1           <= accept && opcode == wpsp_pkg::OP_PROJECT;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      v5           <= v4;
      vf1          <= dv;
      result_valid <= vf1;
    end
  end

endmodule

`default_nettype wire

### hdl/wpsp_checker.sv
// Port-level checks of the projection block, bound to its top level.
// Depends on wpsp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wpsp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_stall,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic                              visible,
  input logic signed [wpsp_pkg::DATA_W-1:0] screen_x,
  input logic signed [wpsp_pkg::DATA_W-1:0] screen_y
);

  // a hidden point carries zero coordinates
  `CHK_HOLDS(a_hidden_zero, !(result_valid && !visible) || (screen_x == 0 && screen_y == 0), "hidden result with nonzero coordinates")

  // a stalled result freezes the pipeline, so nothing new is taken in
  `CHK_HOLDS(a_stall_backs_up, !(result_valid && result_stall) || item_stall, "item taken while result stalled")

  // nothing leaves the pipeline right after reset
  `CHK_STEP(a_reset_empty, rst, !result_valid, "result valid after reset")

  // a stalled result holds
  `CHK_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(visible) && $stable(screen_x) && $stable(screen_y), "stalled result changed")

endmodule

bind world_point_screen_projection wpsp_checker u_wpsp_checker (.*);

`default_nettype wire
